// ===== rtl/direct_mapped_writeback_cache_defines.svh =====
// assertion macros used by the checker file
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DMWC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DMWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dmwc_pkg.sv =====
// shared constants, codes and transaction types of the write-back cache
package dmwc_pkg;

    localparam int DMWC_NUM_LINES      = 64;
    localparam int DMWC_BYTES_PER_LINE = 4;
    localparam int DMWC_NUM_TAGS       = 256;

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;

    typedef enum logic {
        MODE_READ  = 1'b0,
        MODE_WRITE = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic              dirty;
        logic              hit;
        logic [DATA_W-1:0] read_data;
    } t_rsp;

endpackage

// ===== rtl/dmwc_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read per cycle
module dmwc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dmwc_ctrl.sv =====
// cache controller: clear sweep, lookup, write-back, fill and commit sequencer
module dmwc_ctrl
    import dmwc_pkg::*;
#(
    parameter int NUM_LINES      = DMWC_NUM_LINES,
    parameter int BYTES_PER_LINE = DMWC_BYTES_PER_LINE,
    parameter int NUM_TAGS       = DMWC_NUM_TAGS,
    localparam int LINE_W  = $clog2(NUM_LINES),
    localparam int TAG_W   = $clog2(NUM_TAGS),
    localparam int ROW_W   = TAG_W + LINE_W,
    localparam int LINE_DW = BYTES_PER_LINE * DATA_W,
    localparam int CROW_W  = 2 + TAG_W + LINE_DW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  t_req               i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output t_rsp               o_rsp,
    // line ram
    output logic               o_cwe,
    output logic [LINE_W-1:0]  o_cwaddr,
    output logic [CROW_W-1:0]  o_cwdata,
    output logic [LINE_W-1:0]  o_craddr,
    input  logic [CROW_W-1:0]  i_crdata,
    // backing store
    output logic               o_swe,
    output logic [ROW_W-1:0]   o_swaddr,
    output logic [LINE_DW-1:0] o_swdata,
    output logic [ROW_W-1:0]   o_sraddr,
    input  logic [LINE_DW-1:0] i_srdata
);

    localparam int OFF_W     = $clog2(BYTES_PER_LINE);
    localparam int TAG_LSB   = LINE_DW;
    localparam int DIRTY_BIT = LINE_DW + TAG_W;
    localparam int VALID_BIT = LINE_DW + TAG_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_FILL,
        S_COMMIT
    } t_state;

    t_state              r_state;
    logic [ROW_W-1:0]    r_clr;
    t_mode               r_mode;
    logic [ADDR_W-1:0]   r_addr;
    logic [DATA_W-1:0]   r_wdata;
    logic [LINE_DW-1:0]  r_line;
    logic                r_hit;
    logic                r_dirty;
    logic                r_rsp_valid;
    t_rsp                r_rsp;

    logic [ADDR_W-1:0]   w_in_shift;
    logic [ADDR_W-1:0]   w_line_shift;
    logic [ADDR_W-1:0]   w_tag_shift;
    logic [OFF_W-1:0]    w_off;
    logic [LINE_W-1:0]   w_line;
    logic [TAG_W-1:0]    w_tag;
    logic                w_cvalid;
    logic                w_cdirty;
    logic [TAG_W-1:0]    w_ctag;
    logic [LINE_DW-1:0]  w_cdata;
    logic                w_hit;
    logic                w_out_free;
    logic                w_commit;
    logic                w_rsp_load;
    logic                w_dirty_final;
    logic [LINE_DW-1:0]  w_line_final;

    // address split
    assign w_in_shift   = i_req.address >> OFF_W;
    assign w_line_shift = r_addr >> OFF_W;
    assign w_tag_shift  = r_addr >> (OFF_W + LINE_W);
    assign w_off        = r_addr[OFF_W-1:0];
    assign w_line       = w_line_shift[LINE_W-1:0];
    assign w_tag        = w_tag_shift[TAG_W-1:0];

    // line ram read fields
    assign w_cvalid = i_crdata[VALID_BIT];
    assign w_cdirty = i_crdata[DIRTY_BIT];
    assign w_ctag   = i_crdata[TAG_LSB +: TAG_W];
    assign w_cdata  = i_crdata[LINE_DW-1:0];
    assign w_hit    = w_cvalid && (w_ctag == w_tag);

    assign w_out_free = !r_rsp_valid || i_rsp_ready;
    assign w_commit   = (r_state == S_COMMIT) && ((r_mode == MODE_WRITE) || w_out_free);
    assign w_rsp_load = w_commit && (r_mode == MODE_READ);

    // merge the write byte into the line
    always_comb begin
        w_line_final  = r_line;
        w_dirty_final = r_dirty;
        if (r_mode == MODE_WRITE) begin
            w_line_final[w_off*DATA_W +: DATA_W] = r_wdata;
            w_dirty_final                        = 1'b1;
        end
    end

    // memory controls
    always_comb begin
        o_craddr = w_in_shift[LINE_W-1:0];
        o_sraddr = {w_tag, w_line};
        o_cwe    = 1'b0;
        o_cwaddr = w_line;
        o_cwdata = {1'b1, w_dirty_final, w_tag, w_line_final};
        o_swe    = 1'b0;
        o_swaddr = {w_ctag, w_line};
        o_swdata = w_cdata;
        unique case (r_state)
            S_CLEAR: begin
                o_cwe    = 1'b1;
                o_cwaddr = r_clr[LINE_W-1:0];
                o_cwdata = '0;
                o_swe    = 1'b1;
                o_swaddr = r_clr;
                o_swdata = '0;
            end
            S_LOOK: begin
                // evict a dirty line before its slot is refilled
                o_swe = !w_hit && w_cvalid && w_cdirty;
            end
            S_COMMIT: begin
                o_cwe = w_commit;
            end
            S_IDLE, S_FILL: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            // a new read result replaces one that drains in the same cycle
            if (w_rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (r_rsp_valid && i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_mode  <= i_req.mode;
                        r_addr  <= i_req.address;
                        r_wdata <= i_req.write_data;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_hit <= w_hit;
                    if (w_hit) begin
                        r_line  <= w_cdata;
                        r_dirty <= w_cdirty;
                        r_state <= S_COMMIT;
                    end else begin
                        r_dirty <= 1'b0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_line  <= i_srdata;
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (w_commit) begin
                        if (r_mode == MODE_READ) begin
                            r_rsp.read_data <= w_line_final[w_off*DATA_W +: DATA_W];
                            r_rsp.hit       <= r_hit;
                            r_rsp.dirty     <= w_dirty_final;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== rtl/direct_mapped_writeback_cache.sv =====
// top level of the direct-mapped write-back write-allocate byte cache
// Direct-mapped, write-back, write-allocate byte cache in front of an internal
// backing store of NUM_TAGS * NUM_LINES * BYTES_PER_LINE bytes that reads as zero
// after reset. The three sizes are powers of two; the address splits into offset,
// line index and tag from the low bits up (bits 1..0, 7..2 and 15..8 by default).
// Both the line ram and the backing store are one line wide, so a write-back and a
// refill each move a whole line in one access. After reset the block sweeps the
// backing store and the line ram to zero, one store row per cycle, over all
// NUM_TAGS * NUM_LINES store rows (16384 by default); s_axis_tready stays low meanwhile.
// The block then works on one transaction at a time: accept, line ram lookup, on a
// miss the backing store read, then commit, each ram read being registered. The
// result register loads at commit. A write gives no result; a read gives one result,
// which waits in an output register while the next transaction is taken, and a read
// that completes while that register is still full waits for it to drain.
module direct_mapped_writeback_cache
    import dmwc_pkg::*;
#(
    parameter int NUM_LINES      = DMWC_NUM_LINES,
    parameter int BYTES_PER_LINE = DMWC_BYTES_PER_LINE,
    parameter int NUM_TAGS       = DMWC_NUM_TAGS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // address[15:0], write_data[23:16]
    input  logic                 s_axis_tuser,  // mode: 0 read, 1 write
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // read_data[7:0], hit[8], dirty[9], zero
);

    localparam int LINE_W  = $clog2(NUM_LINES);
    localparam int TAG_W   = $clog2(NUM_TAGS);
    localparam int ROW_W   = TAG_W + LINE_W;
    localparam int LINE_DW = BYTES_PER_LINE * DATA_W;
    localparam int CROW_W  = 2 + TAG_W + LINE_DW;

    t_req                w_req;
    t_rsp                w_rsp;

    // line ram port: valid, dirty, tag and line bytes per row
    logic                w_cwe;
    logic [LINE_W-1:0]   w_cwaddr;
    logic [CROW_W-1:0]   w_cwdata;
    logic [LINE_W-1:0]   w_craddr;
    logic [CROW_W-1:0]   w_crdata;

    // backing store port: one line per row, addressed by {tag, line}
    logic                w_swe;
    logic [ROW_W-1:0]    w_swaddr;
    logic [LINE_DW-1:0]  w_swdata;
    logic [ROW_W-1:0]    w_sraddr;
    logic [LINE_DW-1:0]  w_srdata;

    // unpack the request transaction
    assign w_req.mode       = t_mode'(s_axis_tuser);
    assign w_req.address    = s_axis_tdata[ADDR_W-1:0];
    assign w_req.write_data = s_axis_tdata[ADDR_W +: DATA_W];

    // pack the result transaction, zero padded to whole bytes
    assign m_axis_tdata = {{(M_TDATA_W - $bits(t_rsp)){1'b0}}, w_rsp};

    dmwc_ctrl #(
        .NUM_LINES      (NUM_LINES),
        .BYTES_PER_LINE (BYTES_PER_LINE),
        .NUM_TAGS       (NUM_TAGS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (w_req),
        .o_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .o_rsp       (w_rsp),
        .o_cwe       (w_cwe),
        .o_cwaddr    (w_cwaddr),
        .o_cwdata    (w_cwdata),
        .o_craddr    (w_craddr),
        .i_crdata    (w_crdata),
        .o_swe       (w_swe),
        .o_swaddr    (w_swaddr),
        .o_swdata    (w_swdata),
        .o_sraddr    (w_sraddr),
        .i_srdata    (w_srdata)
    );

    dmwc_ram #(
        .DEPTH (NUM_LINES),
        .WIDTH (CROW_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_cwe),
        .i_waddr (w_cwaddr),
        .i_wdata (w_cwdata),
        .i_raddr (w_craddr),
        .o_rdata (w_crdata)
    );

    dmwc_ram #(
        .DEPTH (NUM_TAGS * NUM_LINES),
        .WIDTH (LINE_DW)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (w_swe),
        .i_waddr (w_swaddr),
        .i_wdata (w_swdata),
        .i_raddr (w_sraddr),
        .o_rdata (w_srdata)
    );

endmodule

// ===== rtl/dmwc_checker.sv =====
// port-level checker for the write-back cache and its bind
`include "direct_mapped_writeback_cache_defines.svh"

module dmwc_checker
    import dmwc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata   // read_data[7:0], hit[8], dirty[9]
);

    // a stalled result holds
    `DMWC_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // a line is clean after a refill, so a dirty read must be a hit
    `DMWC_ASSERT_IMP(a_dirty_hit, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[DATA_W+1], m_axis_tdata[DATA_W], "dirty result on a miss")

    // one transaction in flight at a time
    `DMWC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while one is in flight")

    // padding bits of the result stay zero
    `DMWC_ASSERT_IMP(a_rsp_pad, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[M_TDATA_W-1:DATA_W+2] == '0, "nonzero result padding")

endmodule

bind direct_mapped_writeback_cache dmwc_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
